// File: src/bmfp_pkg.sv
// ----------------------------------------------------------------------------
// bmfp_pkg: shared types and constants for the bike metric frame parser
// Frame marker bytes, result kind codes and the result record.
// ----------------------------------------------------------------------------
package bmfp_pkg;

    localparam int FRAME_BYTES_DEF = 10;

    localparam logic [7:0] DIR_FROM_BIKE  = 8'hF1;
    localparam logic [7:0] MET_POWER      = 8'h44;
    localparam logic [7:0] MET_CADENCE    = 8'h41;
    localparam logic [7:0] MET_RAW_RES    = 8'h4A;
    localparam logic [7:0] MET_SCALED_RES = 8'h49;
    localparam logic [7:0] STOP_MARK      = 8'hF6;
    localparam logic [7:0] ASCII_ZERO     = 8'h30;

    // floor(v / 10) == (v * 52429) >> 19 for every 16-bit v
    localparam logic [16:0] RECIP_TEN   = 17'd52429;
    localparam int          RECIP_SHIFT = 19;

    typedef enum logic [2:0] {
        KIND_POWER    = 3'd0,
        KIND_CADENCE  = 3'd1,
        KIND_RESIST   = 3'd2,
        KIND_IGNORED  = 3'd3,
        KIND_REJECTED = 3'd4
    } t_kind;

    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic [15:0] value;
    } t_result;

endpackage

// File: src/bmfp_in_reg.sv
// ----------------------------------------------------------------------------
// bmfp_in_reg: input register
// Captures one received byte per transaction and holds it until the parser
// consumes it.
// ----------------------------------------------------------------------------
module bmfp_in_reg
    import bmfp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_byte,
    input  logic       i_start,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_byte,
    output logic       o_start
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_start;

    assign o_stall = r_valid && !i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_byte  <= i_byte;
            r_start <= i_start;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_start = r_start;

endmodule

// File: src/bmfp_parse.sv
// ----------------------------------------------------------------------------
// bmfp_parse: frame parser
// Running frame state, updated once per consumed byte; produces the result
// record at the stop byte or at an oversized length byte.
// ----------------------------------------------------------------------------
module bmfp_parse
    import bmfp_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic       i_start,
    output t_result    o_res
);

    localparam int POS_W   = $clog2(FRAME_BYTES);
    localparam int MAX_LEN = FRAME_BYTES - 5;

    logic [POS_W-1:0] r_pos,    n_pos;
    logic             r_dir_ok, n_dir_ok;
    t_kind            r_metric, n_metric;
    logic [POS_W-1:0] r_len,    n_len;
    logic [7:0]       r_sum,    n_sum;
    logic [15:0]      r_acc,    n_acc;
    logic [15:0]      r_weight, n_weight;
    logic             r_sum_ok, n_sum_ok;

    logic [POS_W:0]   pos_ext;
    logic [POS_W:0]   digit_end;
    logic [15:0]      digit;
    logic [31:0]      term;
    logic [32:0]      quot_prod;
    logic [15:0]      quot;
    t_result          res;

    assign pos_ext   = {1'b0, r_pos};
    assign digit_end = (POS_W + 1)'(3) + {1'b0, r_len};
    assign digit     = {8'h00, i_byte} - {8'h00, ASCII_ZERO};
    assign term      = r_weight * digit;
    assign quot_prod = r_acc * RECIP_TEN;
    assign quot      = 16'(quot_prod >> RECIP_SHIFT);

    always_comb begin
        n_pos    = r_pos;
        n_dir_ok = r_dir_ok;
        n_metric = r_metric;
        n_len    = r_len;
        n_sum    = r_sum;
        n_acc    = r_acc;
        n_weight = r_weight;
        n_sum_ok = r_sum_ok;
        res      = '{valid: 1'b0, kind: KIND_REJECTED, value: 16'h0000};

        if (i_start) begin
            n_dir_ok = (i_byte == DIR_FROM_BIKE);
            n_sum    = i_byte;
            n_acc    = 16'h0000;
            n_weight = 16'h0001;
            n_metric = KIND_IGNORED;
            n_len    = '0;
            n_sum_ok = 1'b0;
            n_pos    = POS_W'(1);
        end else if (r_pos == '0) begin
            // byte outside a frame: dropped
        end else if (r_pos == POS_W'(1)) begin
            case (i_byte)
                MET_POWER:      n_metric = KIND_POWER;
                MET_CADENCE:    n_metric = KIND_CADENCE;
                MET_SCALED_RES: n_metric = KIND_RESIST;
                default:        n_metric = KIND_IGNORED;
            endcase
            n_sum = r_sum + i_byte;
            n_pos = POS_W'(2);
        end else if (r_pos == POS_W'(2)) begin
            n_sum = r_sum + i_byte;
            n_len = POS_W'(i_byte);
            if (i_byte > 8'(MAX_LEN)) begin
                res   = '{valid: 1'b1, kind: KIND_REJECTED, value: 16'h0000};
                n_pos = '0;
            end else begin
                n_pos = POS_W'(3);
            end
        end else if (pos_ext < digit_end) begin
            n_acc    = r_acc + term[15:0];
            n_weight = (r_weight << 3) + (r_weight << 1);
            n_sum    = r_sum + i_byte;
            n_pos    = r_pos + POS_W'(1);
        end else if (pos_ext == digit_end) begin
            // checksum byte: compare now, sum is complete
            n_sum_ok = (r_sum == i_byte);
            n_pos    = r_pos + POS_W'(1);
        end else begin
            n_pos = '0;
            if (r_dir_ok && r_sum_ok && i_byte == STOP_MARK) begin
                case (r_metric)
                    KIND_POWER:   res = '{valid: 1'b1, kind: KIND_POWER,   value: quot};
                    KIND_CADENCE: res = '{valid: 1'b1, kind: KIND_CADENCE, value: r_acc};
                    KIND_RESIST:  res = '{valid: 1'b1, kind: KIND_RESIST,  value: r_acc};
                    default:      res = '{valid: 1'b1, kind: KIND_IGNORED, value: 16'h0000};
                endcase
            end else begin
                res = '{valid: 1'b1, kind: KIND_REJECTED, value: 16'h0000};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_step) begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_dir_ok <= n_dir_ok;
            r_metric <= n_metric;
            r_len    <= n_len;
            r_sum    <= n_sum;
            r_acc    <= n_acc;
            r_weight <= n_weight;
            r_sum_ok <= n_sum_ok;
        end
    end

    always_comb begin
        o_res       = res;
        o_res.valid = res.valid && i_step;
    end

    a_start_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_start |-> !o_res.valid)
        else $error("result produced on a frame start byte");

    a_result_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_res.valid |=> r_pos == '0)
        else $error("parser not idle after result");

    a_idle_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !i_start && r_pos == '0 |=> r_pos == '0 && !$past(o_res.valid))
        else $error("stray byte opened a frame or gave a result");

endmodule

// File: src/bmfp_out_reg.sv
// ----------------------------------------------------------------------------
// bmfp_out_reg: result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module bmfp_out_reg
    import bmfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_result     i_res,
    output logic        o_free,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_kind,
    output logic [15:0] o_value
);

    logic        r_valid;
    t_kind       r_kind;
    logic [15:0] r_value;

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_res.valid) begin
            r_kind  <= i_res.kind;
            r_value <= i_res.value;
        end
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_value = r_value;

endmodule

// File: src/bike_metric_frame_parser.sv
// ----------------------------------------------------------------------------
// bike_metric_frame_parser: serial metric frame decoder
// Input register, single-pass frame parser and result register.
// Path: the stop (or oversized length) byte is captured in the input register;
//   the parser reads it there and writes its result to the result register,
//   which drives the outputs. Throughput: one byte per cycle while the result
//   register is free; the parser state updates once per byte.
// Reset: synchronous, active low; clears both valid flags and the byte
//   position, so the parser starts idle with no frame open.
// ----------------------------------------------------------------------------
module bike_metric_frame_parser
    import bmfp_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_frame_start,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_reading_kind,
    output logic [15:0] o_reading_value
);

    logic       in_valid;
    logic [7:0] in_byte;
    logic       in_start;
    logic       out_free;
    logic       step;
    t_result    res;

    assign step = in_valid && out_free;

    bmfp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_byte  (i_rx_byte),
        .i_start (i_frame_start),
        .i_take  (out_free),
        .o_valid (in_valid),
        .o_byte  (in_byte),
        .o_start (in_start)
    );

    bmfp_parse #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (in_byte),
        .i_start (in_start),
        .o_res   (res)
    );

    bmfp_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_kind  (o_reading_kind),
        .o_value (o_reading_value)
    );

endmodule

// File: tb/bike_metric_frame_parser_tb.sv
// ----------------------------------------------------------------------------
// bike_metric_frame_parser_tb: self-checking bench for the frame parser
// Streams directed and random serial frames into the parser. A byte-level
// model predicts each reading, and every output transaction is checked
// against it in order. Both sides idle and stall in random bursts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bike_metric_frame_parser_tb;
    import bmfp_pkg::*;

    localparam int MAX_LEN      = FRAME_BYTES_DEF - 5;
    localparam int RANDOM_BYTES = 1200;
    localparam int QUIET_TAIL   = 150;
    localparam int LIMIT_CYCLES = 400000;

    typedef struct packed {
        logic [7:0] rx;
        logic       start;
        logic       hold;   // wait for all readings before sending
    } t_rx_item;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] value;
    } t_reading;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_rx_byte;
    logic        i_frame_start;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [2:0]  o_reading_kind;
    logic [15:0] o_reading_value;

    t_rx_item rx_backlog[$];
    t_reading expected_readings[$];
    t_rx_item next_item;
    t_reading want;

    logic        in_taken = 1'b0;
    int          send_gap = 0;
    int          stall_left = 0;
    int          mismatches = 0;
    int unsigned cycle_count = 0;

    // parser model state
    logic [3:0]  frame_pos = '0;
    logic [7:0]  frame_dir = '0;
    logic [7:0]  frame_met = '0;
    logic [7:0]  frame_len = '0;
    logic [7:0]  frame_sum = '0;
    logic [7:0]  frame_chk = '0;
    logic [15:0] frame_acc = '0;
    logic [16:0] frame_wgt = 17'd1;

    bike_metric_frame_parser u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_rx_byte       (i_rx_byte),
        .i_frame_start   (i_frame_start),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_reading_kind  (o_reading_kind),
        .o_reading_value (o_reading_value)
    );

    always #5 i_clk = ~i_clk;

    task automatic post_reading(input t_kind kind, input logic [15:0] value);
        t_reading r;
        r.kind  = kind;
        r.value = value;
        expected_readings.push_back(r);
        frame_pos = '0;
    endtask

    // advance the model by one accepted byte
    task automatic parse_byte(input logic [7:0] b, input logic start);
        logic [15:0] digit;
        logic [15:0] term;
        if (start) begin
            frame_dir = b;
            frame_sum = b;
            frame_acc = '0;
            frame_wgt = 17'd1;
            frame_met = '0;
            frame_len = '0;
            frame_chk = '0;
            frame_pos = 4'd1;
        end else if (frame_pos == 4'd0) begin
            // outside a frame: dropped
        end else if (frame_pos == 4'd1) begin
            frame_met = b;
            frame_sum = frame_sum + b;
            frame_pos = 4'd2;
        end else if (frame_pos == 4'd2) begin
            frame_len = b;
            frame_sum = frame_sum + b;
            if (int'(b) > MAX_LEN) begin
                post_reading(KIND_REJECTED, 16'd0);
            end else begin
                frame_pos = 4'd3;
            end
        end else if (int'(frame_pos) < 3 + int'(frame_len)) begin
            digit     = {8'h00, b} - {8'h00, ASCII_ZERO};
            term      = frame_wgt[15:0] * digit;
            frame_acc = frame_acc + term;
            frame_wgt = frame_wgt * 17'd10;
            frame_sum = frame_sum + b;
            frame_pos = frame_pos + 4'd1;
        end else if (int'(frame_pos) == 3 + int'(frame_len)) begin
            frame_chk = b;
            frame_pos = frame_pos + 4'd1;
        end else if (frame_dir == DIR_FROM_BIKE && b == STOP_MARK && frame_sum == frame_chk) begin
            case (frame_met)
                MET_POWER:      post_reading(KIND_POWER, frame_acc / 16'd10);
                MET_CADENCE:    post_reading(KIND_CADENCE, frame_acc);
                MET_SCALED_RES: post_reading(KIND_RESIST, frame_acc);
                default:        post_reading(KIND_IGNORED, 16'd0);
            endcase
        end else begin
            post_reading(KIND_REJECTED, 16'd0);
        end
    endtask

    task automatic log_mismatch(input string what, input t_reading exp_r);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s: expected kind %0d value %0d, got kind %0d value %0d",
                     $realtime, what, exp_r.kind, exp_r.value, o_reading_kind, o_reading_value);
        end
    endtask

    // sample both channels
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("bike_metric_frame_parser: mismatch");
            $finish;
        end else if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_readings.size() == 0) begin
                    log_mismatch("unexpected reading", '0);
                end else begin
                    want = expected_readings.pop_front();
                    if (o_reading_kind !== want.kind || o_reading_value !== want.value) begin
                        log_mismatch("wrong reading", want);
                    end
                end
            end
            in_taken <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall) begin
                parse_byte(i_rx_byte, i_frame_start);
            end
        end
    end

    // byte driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_taken) begin
            // stalled: hold the transaction
        end else if (send_gap > 0) begin
            send_gap   <= send_gap - 1;
            i_in_valid <= 1'b0;
        end else if (rx_backlog.size() == 0 ||
                     (rx_backlog[0].hold && expected_readings.size() != 0)) begin
            i_in_valid <= 1'b0;
        end else if (rx_backlog.size() > QUIET_TAIL && !cycle_count[10] &&
                     $urandom_range(0, 9) == 0) begin
            i_in_valid <= 1'b0;
            send_gap   <= $urandom_range(0, 17);
        end else begin
            next_item     = rx_backlog.pop_front();
            i_rx_byte     <= next_item.rx;
            i_frame_start <= next_item.start;
            i_in_valid    <= 1'b1;
        end
    end

    // reading receiver stall
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (rx_backlog.size() > QUIET_TAIL && !cycle_count[9] &&
                     $urandom_range(0, 7) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 17);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic start, input logic hold);
        t_rx_item it;
        it.rx    = b;
        it.start = start;
        it.hold  = hold;
        rx_backlog.push_back(it);
    endtask

    // digits are sent least significant first
    function automatic logic [39:0] ascii_digits(input int unsigned v);
        logic [39:0] d;
        for (int i = 0; i < 5; i++) begin
            d[8*i +: 8] = ASCII_ZERO + 8'(v % 10);
            v = v / 10;
        end
        return d;
    endfunction

    task automatic queue_frame(input logic [7:0] dir, input logic [7:0] met,
                               input logic [7:0] len, input logic [39:0] digits,
                               input logic [7:0] chk_err, input logic [7:0] stop,
                               input logic hold);
        logic [7:0] sum;
        sum = dir + met + len;
        push_byte(dir, 1'b1, hold);
        push_byte(met, 1'b0, 1'b0);
        push_byte(len, 1'b0, 1'b0);
        if (int'(len) <= MAX_LEN) begin
            for (int i = 0; i < int'(len); i++) begin
                push_byte(digits[8*i +: 8], 1'b0, 1'b0);
                sum = sum + digits[8*i +: 8];
            end
            push_byte(sum + chk_err, 1'b0, 1'b0);
            push_byte(stop, 1'b0, 1'b0);
        end
    endtask

    initial begin
        int          goal;
        int          pick;
        logic [7:0]  dir;
        logic [7:0]  met;
        logic [7:0]  len;
        logic [39:0] digits;
        logic [7:0]  chk_err;
        logic [7:0]  stop;

        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_rx_byte     = 8'h00;
        i_frame_start = 1'b0;
        i_out_stall   = 1'b0;

        // directed: stray bytes while idle
        push_byte(8'hF6, 1'b0, 1'b0);
        push_byte(8'hF1, 1'b0, 1'b0);
        queue_frame(DIR_FROM_BIKE, MET_POWER, 8'd5, ascii_digits(12345), 8'd0, STOP_MARK, 1'b0);
        queue_frame(DIR_FROM_BIKE, MET_POWER, 8'd0, ascii_digits(0), 8'd0, STOP_MARK, 1'b0);
        // wraps past 65535
        queue_frame(DIR_FROM_BIKE, MET_POWER, 8'd5, ascii_digits(99999), 8'd0, STOP_MARK, 1'b0);
        queue_frame(DIR_FROM_BIKE, MET_CADENCE, 8'd2, ascii_digits(90), 8'd0, STOP_MARK, 1'b0);
        queue_frame(DIR_FROM_BIKE, MET_SCALED_RES, 8'd1, ascii_digits(7), 8'd0, STOP_MARK,
                    1'b0);
        queue_frame(DIR_FROM_BIKE, MET_RAW_RES, 8'd3, ascii_digits(512), 8'd0, STOP_MARK, 1'b0);
        queue_frame(DIR_FROM_BIKE, 8'h00, 8'd2, ascii_digits(42), 8'd0, STOP_MARK, 1'b0);
        queue_frame(8'hF0, MET_CADENCE, 8'd2, ascii_digits(42), 8'd0, STOP_MARK, 1'b0);
        queue_frame(DIR_FROM_BIKE, MET_CADENCE, 8'd2, ascii_digits(42), 8'd0, 8'hF5, 1'b0);
        queue_frame(DIR_FROM_BIKE, MET_CADENCE, 8'd2, ascii_digits(42), 8'd1, STOP_MARK, 1'b0);
        // length one past the limit, and the largest length byte
        queue_frame(DIR_FROM_BIKE, MET_POWER, 8'(MAX_LEN + 1), '0, 8'd0, STOP_MARK, 1'b0);
        queue_frame(DIR_FROM_BIKE, MET_POWER, 8'hFF, '0, 8'd0, STOP_MARK, 1'b0);
        // non-digit payload bytes
        queue_frame(DIR_FROM_BIKE, MET_CADENCE, 8'd2, {24'h0, 8'h00, 8'hFF}, 8'd0, STOP_MARK,
                    1'b0);
        // new frame opened in the middle of another
        push_byte(DIR_FROM_BIKE, 1'b1, 1'b0);
        push_byte(MET_CADENCE, 1'b0, 1'b0);
        push_byte(8'd3, 1'b0, 1'b0);
        push_byte(8'h35, 1'b0, 1'b0);
        queue_frame(DIR_FROM_BIKE, MET_SCALED_RES, 8'd4, ascii_digits(6543), 8'd0, STOP_MARK,
                    1'b0);

        // random: mostly well-formed frames, some noise and cut-off frames
        goal = rx_backlog.size() + RANDOM_BYTES;
        pick = 0;
        while (rx_backlog.size() < goal) begin
            if (pick == 0 || $urandom_range(0, 99) < 75) begin
                dir = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255)) : DIR_FROM_BIKE;
                case ($urandom_range(0, 5))
                    0:       met = MET_CADENCE;
                    1:       met = MET_SCALED_RES;
                    2:       met = MET_RAW_RES;
                    3:       met = 8'($urandom_range(0, 255));
                    default: met = MET_POWER;
                endcase
                len = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
                                                   : 8'($urandom_range(0, MAX_LEN));
                if ($urandom_range(0, 9) == 0) begin
                    digits[31:0]  = $urandom;
                    digits[39:32] = 8'($urandom_range(0, 255));
                end else begin
                    digits = ascii_digits($urandom_range(0, 99999));
                end
                chk_err = ($urandom_range(0, 11) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
                stop = ($urandom_range(0, 11) == 0) ? 8'($urandom_range(0, 255)) : STOP_MARK;
                queue_frame(dir, met, len, digits, chk_err, stop,
                            pick == 0 || $urandom_range(0, 149) == 0);
            end else if ($urandom_range(0, 1) == 0) begin
                repeat ($urandom_range(1, 6)) begin
                    push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, 1'b0);
                end
            end else begin
                push_byte(DIR_FROM_BIKE, 1'b1, 1'b0);
                repeat ($urandom_range(0, 7)) begin
                    push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                end
            end
            pick++;
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (rx_backlog.size() != 0 || i_in_valid || expected_readings.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);

        if (mismatches == 0 && expected_readings.size() == 0) begin
            $display("bike_metric_frame_parser: match");
        end else begin
            $display("bike_metric_frame_parser: mismatch");
        end
        $finish;
    end

endmodule
